// ----- rtl/core/p2d_pkg.sv -----
// Package for the streaming 2-D pooling block.
// Holds default sizes, field widths and the configuration register indexes.
// No dependencies.
package p2d_pkg;

	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_KERNEL_DEF = 8;
	localparam int MAX_HEIGHT     = 1024;

	localparam int SAMPLE_W   = 16;
	localparam int ROW_W      = 10;
	localparam int COL_W      = 10;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;
	localparam int GEOM_W     = 11;
	localparam int KS_W       = 4;

	localparam int OUT_DATA_W = 40;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POOL_MODE    = 3'd0,
		REG_KERNEL_SIZE  = 3'd1,
		REG_STRIDE_STEP  = 3'd2,
		REG_PLANE_WIDTH  = 3'd3,
		REG_PLANE_HEIGHT = 3'd4
	} p2d_reg_t;

	localparam logic MODE_MAX = 1'b0;
	localparam logic MODE_AVG = 1'b1;

	localparam logic [KS_W-1:0]   KERNEL_RST = 4'd2;
	localparam logic [KS_W-1:0]   STRIDE_RST = 4'd2;
	localparam logic [GEOM_W-1:0] WIDTH_RST  = 11'd1024;
	localparam logic [GEOM_W-1:0] HEIGHT_RST = 11'd1024;

endpackage

// ----- rtl/core/p2d_div.sv -----
// Iterative restoring divider for the pooling block, one quotient bit per cycle.
// Unsigned numerator and denominator; used for the window average.
// No dependencies.
module p2d_div #(
	parameter int NUM_W = 22,
	parameter int DEN_W = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [NUM_W-1:0] quo
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;

	logic [DEN_W:0]   shifted;
	logic             fits;

	always_comb begin
		shifted = {rem_q, quo_q[NUM_W-1]};
		fits    = (shifted >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? DEN_W'(shifted - {1'b0, den_q}) : DEN_W'(shifted);
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- rtl/core/pooling_2d_stream.sv -----
// Streaming 2-D max / average pooling over raster-ordered channel planes.
// Uses p2d_pkg for constants and p2d_div for the average division.
//
//  channel   | dir | handshake         | payload
//  ----------+-----+-------------------+---------------------------------------
//  s_*       | in  | s_tvalid/s_tready | s_tdata: sample_value
//  m_*       | out | m_tvalid/m_tready | m_tdata: pooled_value, out_row, out_col
//            |     |                   | m_tlast: plane_done
//  cfg_*     | in  | cfg_we            | cfg_index, cfg_data
//
// A sample that closes no window does not hold the input. One that closes a window
// holds s_tready low while the window is walked: k*k reads through the single
// line-store read port, then in average mode SUM_W divider steps.
// After reset and after each geometry register write there is a setup step (init_q).
// A finished result waits in the output register while m_tready is low; the next window
// result then waits in S_OUT, and the input is held back with it.
module pooling_2d_stream #(
	parameter int MAX_WIDTH  = p2d_pkg::MAX_WIDTH_DEF,
	parameter int MAX_KERNEL = p2d_pkg::MAX_KERNEL_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// s_tdata[15:0] sample_value
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [p2d_pkg::SAMPLE_W-1:0]    s_tdata,
	// m_tdata[15:0] pooled_value, [25:16] out_row, [35:26] out_col, [39:36] zero
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [p2d_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                            m_tlast,
	input  logic                            cfg_we,
	input  logic [p2d_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [p2d_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int SW     = p2d_pkg::SAMPLE_W;
	localparam int ROW_W  = p2d_pkg::ROW_W;
	localparam int COLW   = $clog2(MAX_WIDTH);
	localparam int WW     = $clog2(MAX_WIDTH + 1);
	localparam int RSW    = $clog2(MAX_KERNEL);
	localparam int KW     = $clog2(MAX_KERNEL + 1);
	localparam int DEPTH  = MAX_KERNEL * MAX_WIDTH;
	localparam int AW     = $clog2(DEPTH);
	localparam int SUM_W  = SW + $clog2(MAX_KERNEL * MAX_KERNEL);
	localparam int KKW    = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
	localparam int NHC_W  = $clog2(MAX_WIDTH + 16);
	localparam int NHR_W  = ROW_W + 1;
	localparam int HW     = p2d_pkg::GEOM_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_READ,
		S_WAIT,
		S_CALC,
		S_DIV,
		S_OUT
	} state_t;

	// Configuration registers.
	logic                       mode_q;
	logic [p2d_pkg::KS_W-1:0]   kernel_q;
	logic [p2d_pkg::KS_W-1:0]   stride_q;
	logic [p2d_pkg::GEOM_W-1:0] width_q;
	logic [p2d_pkg::GEOM_W-1:0] height_q;

	logic [KW-1:0]    eff_k;
	logic [KW-1:0]    k_m1;
	logic [3:0]       eff_s;
	logic [WW-1:0]    eff_w;
	logic [HW-1:0]    eff_h;

	// Position and window tracking.
	state_t            state_q;
	logic              init_q;
	logic [COLW-1:0]   col_q;
	logic [ROW_W-1:0]  row_q;
	logic [RSW-1:0]    rslot_q;
	logic [NHC_W-1:0]  nh_col_q;
	logic [NHR_W-1:0]  nh_row_q;
	logic [COLW-1:0]   ow_q;
	logic [ROW_W-1:0]  oh_q;

	// Window walk.
	logic [KW-1:0]     i_q;
	logic [KW-1:0]     j_q;
	logic [RSW-1:0]    rs_q;
	logic [COLW-1:0]   cs_q;
	logic [COLW-1:0]   cr_q;
	logic [COLW-1:0]   win_ow_q;
	logic [ROW_W-1:0]  win_oh_q;
	logic              win_last_q;

	logic                    rd_vld_s1;
	logic signed [SW-1:0]    rd_data_s1;
	logic signed [SUM_W-1:0] acc_q;
	logic signed [SW-1:0]    mx_q;
	logic                    first_q;
	logic                    neg_q;
	logic [SW-1:0]           res_q;

	logic              m_valid_q;
	logic [SW-1:0]     m_pool_q;
	logic [ROW_W-1:0]  m_row_q;
	logic [p2d_pkg::COL_W-1:0] m_col_q;
	logic              m_last_q;

	logic [SW-1:0]     line_mem [0:DEPTH-1];

	logic              accept;
	logic              col_hit;
	logic              row_hit;
	logic              win_hit;
	logic              row_end;
	logic              plane_end;
	logic              geom_wr;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr;
	logic [RSW:0]      rs_sub;
	logic [RSW-1:0]    rs_start;
	logic [RSW-1:0]    rs_next;
	logic [SUM_W-1:0]  acc_mag;
	logic [KKW-1:0]    kk;
	logic              div_start;
	logic              div_done;
	logic [SUM_W-1:0]  div_quo;
	logic [SUM_W-1:0]  quo_signed;

	always_comb begin
		if (kernel_q == '0)
			eff_k = KW'(1);
		else if (32'(kernel_q) > MAX_KERNEL)
			eff_k = KW'(MAX_KERNEL);
		else
			eff_k = KW'(kernel_q);
		k_m1  = eff_k - KW'(1);
		eff_s = (stride_q == '0) ? 4'd1 : stride_q;
		if (width_q == '0)
			eff_w = WW'(1);
		else if (32'(width_q) > MAX_WIDTH)
			eff_w = WW'(MAX_WIDTH);
		else
			eff_w = WW'(width_q);
		if (height_q == '0)
			eff_h = HW'(1);
		else if (32'(height_q) > p2d_pkg::MAX_HEIGHT)
			eff_h = HW'(p2d_pkg::MAX_HEIGHT);
		else
			eff_h = height_q;
	end

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (state_q == S_IDLE) && !init_q;
	assign geom_wr   = cfg_we && (cfg_index == p2d_pkg::REG_KERNEL_SIZE ||
		cfg_index == p2d_pkg::REG_STRIDE_STEP || cfg_index == p2d_pkg::REG_PLANE_WIDTH ||
		cfg_index == p2d_pkg::REG_PLANE_HEIGHT);

	// Window ends are tracked by the next bottom row and right column on the stride grid.
	assign col_hit   = (NHC_W'(col_q) == nh_col_q);
	assign row_hit   = (NHR_W'(row_q) == nh_row_q);
	assign win_hit   = col_hit && row_hit;
	assign row_end   = (NHC_W'(col_q) + NHC_W'(1)) >= NHC_W'(eff_w);
	assign plane_end = (NHR_W'(row_q) + NHR_W'(1)) >= NHR_W'(eff_h);

	always_comb begin
		rs_sub = (RSW+1)'(rslot_q) + (RSW+1)'(MAX_KERNEL) - (RSW+1)'(k_m1);
		if (rs_sub >= (RSW+1)'(MAX_KERNEL))
			rs_start = RSW'(rs_sub - (RSW+1)'(MAX_KERNEL));
		else
			rs_start = RSW'(rs_sub);
		rs_next = (32'(rs_q) == MAX_KERNEL - 1) ? '0 : rs_q + RSW'(1);
	end

	assign wr_addr = AW'(rslot_q) * AW'(MAX_WIDTH) + AW'(col_q);
	assign rd_addr = AW'(rs_q) * AW'(MAX_WIDTH) + AW'(cr_q);

	always_ff @(posedge clk) begin
		if (accept)
			line_mem[wr_addr] <= s_tdata;
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= line_mem[rd_addr];
	end

	assign acc_mag    = acc_q[SUM_W-1] ? SUM_W'(-acc_q) : SUM_W'(acc_q);
	assign kk         = KKW'(eff_k) * KKW'(eff_k);
	assign div_start  = (state_q == S_CALC) && (mode_q == p2d_pkg::MODE_AVG);
	assign quo_signed = neg_q ? SUM_W'(-div_quo) : div_quo;

	p2d_div #(
		.NUM_W (SUM_W),
		.DEN_W (KKW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_mag),
		.den    (kk),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			init_q    <= 1'b1;
			mode_q    <= p2d_pkg::MODE_MAX;
			kernel_q  <= p2d_pkg::KERNEL_RST;
			stride_q  <= p2d_pkg::STRIDE_RST;
			width_q   <= p2d_pkg::WIDTH_RST;
			height_q  <= p2d_pkg::HEIGHT_RST;
			col_q     <= '0;
			row_q     <= '0;
			rslot_q   <= '0;
			nh_col_q  <= '0;
			nh_row_q  <= '0;
			ow_q      <= '0;
			oh_q      <= '0;
			rd_vld_s1 <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= 1'b0;
			if (m_valid_q && m_tready)
				m_valid_q <= 1'b0;

			if (cfg_we) begin
				unique case (cfg_index)
					p2d_pkg::REG_POOL_MODE:    mode_q   <= cfg_data[0];
					p2d_pkg::REG_KERNEL_SIZE:  kernel_q <= cfg_data[p2d_pkg::KS_W-1:0];
					p2d_pkg::REG_STRIDE_STEP:  stride_q <= cfg_data[p2d_pkg::KS_W-1:0];
					p2d_pkg::REG_PLANE_WIDTH:  width_q  <= cfg_data;
					p2d_pkg::REG_PLANE_HEIGHT: height_q <= cfg_data;
					default: ;
				endcase
			end

			if (geom_wr) begin
				col_q   <= '0;
				row_q   <= '0;
				rslot_q <= '0;
				init_q  <= 1'b1;
			end else if (init_q) begin
				nh_col_q <= NHC_W'(k_m1);
				nh_row_q <= NHR_W'(k_m1);
				ow_q     <= '0;
				oh_q     <= '0;
				init_q   <= 1'b0;
			end else if (accept) begin
				if (row_end) begin
					col_q    <= '0;
					nh_col_q <= NHC_W'(k_m1);
					ow_q     <= '0;
					if (plane_end) begin
						row_q    <= '0;
						rslot_q  <= '0;
						nh_row_q <= NHR_W'(k_m1);
						oh_q     <= '0;
					end else begin
						row_q   <= row_q + ROW_W'(1);
						rslot_q <= (32'(rslot_q) == MAX_KERNEL - 1) ? '0 : rslot_q + RSW'(1);
						if (row_hit) begin
							nh_row_q <= nh_row_q + NHR_W'(eff_s);
							oh_q     <= oh_q + ROW_W'(1);
						end
					end
				end else begin
					col_q <= col_q + COLW'(1);
					if (col_hit) begin
						nh_col_q <= nh_col_q + NHC_W'(eff_s);
						ow_q     <= ow_q + COLW'(1);
					end
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept && !geom_wr && win_hit) begin
						state_q    <= S_READ;
						i_q        <= '0;
						j_q        <= '0;
						rs_q       <= rs_start;
						cs_q       <= col_q - COLW'(k_m1);
						cr_q       <= col_q - COLW'(k_m1);
						win_ow_q   <= ow_q;
						win_oh_q   <= oh_q;
						win_last_q <= (NHC_W'(col_q) + NHC_W'(eff_s) >= NHC_W'(eff_w)) &&
							(NHR_W'(row_q) + NHR_W'(eff_s) >= NHR_W'(eff_h));
						acc_q      <= '0;
						first_q    <= 1'b1;
					end
				end
				S_READ: begin
					rd_vld_s1 <= 1'b1;
					if (j_q == k_m1) begin
						j_q  <= '0;
						cr_q <= cs_q;
						i_q  <= i_q + KW'(1);
						rs_q <= rs_next;
						if (i_q == k_m1)
							state_q <= S_WAIT;
					end else begin
						j_q  <= j_q + KW'(1);
						cr_q <= cr_q + COLW'(1);
					end
				end
				S_WAIT: begin
					state_q <= S_CALC;
				end
				S_CALC: begin
					neg_q <= acc_q[SUM_W-1];
					if (mode_q == p2d_pkg::MODE_AVG) begin
						state_q <= S_DIV;
					end else begin
						res_q   <= mx_q;
						state_q <= S_OUT;
					end
				end
				S_DIV: begin
					if (div_done) begin
						res_q   <= quo_signed[SW-1:0];
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q <= 1'b1;
						m_pool_q  <= res_q;
						m_row_q   <= win_oh_q;
						m_col_q   <= p2d_pkg::COL_W'(win_ow_q);
						m_last_q  <= win_last_q;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			// One stored sample arrives per cycle while the window is walked.
			if (rd_vld_s1) begin
				acc_q   <= acc_q + SUM_W'(rd_data_s1);
				first_q <= 1'b0;
				if (first_q || rd_data_s1 > mx_q)
					mx_q <= rd_data_s1;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {4'b0000, m_col_q, m_row_q, m_pool_q};
	assign m_tlast  = m_last_q;

`ifndef SYNTH
	a_rd_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (state_q == S_READ || state_q == S_WAIT))
		else $error("line store data arrived outside a window walk");

	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished while not waiting for it");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(NHC_W'(col_q) < NHC_W'(eff_w)) && (NHR_W'(row_q) < NHR_W'(eff_h)))
		else $error("sample position outside the plane");
`endif

endmodule

// ----- verif/tb_pooling_2d_stream.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for pooling_2d_stream: max and average pooling over raster planes.
// Uses p2d_pkg for widths, register indexes and reset values; needs only the RTL.
module tb_pooling_2d_stream;
	import p2d_pkg::*;

	localparam int MAXK        = MAX_KERNEL_DEF;
	localparam int MAXW        = MAX_WIDTH_DEF;
	localparam int STORE_DEPTH = MAXK * MAXW;
	localparam int ROW_LSB     = SAMPLE_W;
	localparam int COL_LSB     = SAMPLE_W + ROW_W;
	localparam int PAD_LSB     = SAMPLE_W + ROW_W + COL_W;
	// Indexes past the last register; writes to them must be ignored.
	localparam int REG_UNUSED_FIRST = 5;
	localparam int REG_UNUSED_LAST  = 7;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h8000;
	localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'h7FFF;
	localparam int DRAIN_PAD    = 150;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int RANDOM_ITEMS = 600;
	localparam int MIN_RANDOM_RESULTS = 60;

	typedef struct packed {
		logic [SAMPLE_W-1:0] pooled;
		logic [ROW_W-1:0]    row;
		logic [COL_W-1:0]    col;
		logic                done;
	} pool_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [SAMPLE_W-1:0]   s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  m_tlast;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pooling_2d_stream dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the block: window store, position and registers.
	logic signed [SAMPLE_W-1:0] win_store [STORE_DEPTH];
	int                  next_row;
	int                  next_col;
	logic                cur_mode;
	logic [KS_W-1:0]     cur_kernel;
	logic [KS_W-1:0]     cur_stride;
	logic [GEOM_W-1:0]   cur_width;
	logic [GEOM_W-1:0]   cur_height;

	pool_result_t pending_results[$];
	int  fail_count;
	int  samples_sent;
	int  results_predicted;
	int  results_checked;
	int  settings_count;
	bit  gaps_on;
	bit  stalls_on;
	int  hold_request;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("Timeout: the run did not finish in time.");
		$display("*** FAILED ***");
		$finish;
	end

	function automatic void note_failure(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("ERROR: %s", msg);
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_POOL_MODE: begin
				cur_mode = data[0];
				return;
			end
			REG_KERNEL_SIZE:  cur_kernel = data[KS_W-1:0];
			REG_STRIDE_STEP:  cur_stride = data[KS_W-1:0];
			REG_PLANE_WIDTH:  cur_width  = data[GEOM_W-1:0];
			REG_PLANE_HEIGHT: cur_height = data[GEOM_W-1:0];
			default: return;
		endcase
		// Any geometry write starts a fresh plane.
		next_row = 0;
		next_col = 0;
	endfunction

	function automatic void predict_sample(logic [SAMPLE_W-1:0] raw);
		int k, s, w, h, r, c, acc, mx, x;
		bit first;
		pool_result_t res;
		k = (cur_kernel == 0) ? 1 : ((cur_kernel > MAXK) ? MAXK : int'(cur_kernel));
		s = (cur_stride == 0) ? 1 : int'(cur_stride);
		w = (cur_width == 0) ? 1 : ((cur_width > MAXW) ? MAXW : int'(cur_width));
		h = (cur_height == 0) ? 1 : ((cur_height > MAX_HEIGHT) ? MAX_HEIGHT : int'(cur_height));
		r = next_row;
		c = next_col;
		win_store[(r % MAXK) * MAXW + c] = signed'(raw);
		if (k <= w && k <= h && r + 1 >= k && c + 1 >= k &&
		    (r + 1 - k) % s == 0 && (c + 1 - k) % s == 0) begin
			acc = 0;
			mx = 0;
			first = 1'b1;
			for (int i = 0; i < k; i++) begin
				for (int j = 0; j < k; j++) begin
					x = win_store[((r + 1 - k + i) % MAXK) * MAXW + (c + 1 - k + j)];
					acc += x;
					if (first || x > mx)
						mx = x;
					first = 1'b0;
				end
			end
			// Signed integer division truncates toward zero, as the block does.
			res.pooled = (cur_mode == MODE_AVG) ? SAMPLE_W'(acc / (k * k)) : SAMPLE_W'(mx);
			res.row = ROW_W'((r + 1 - k) / s);
			res.col = COL_W'((c + 1 - k) / s);
			res.done = ((r + 1 - k) / s == (h - k) / s) && ((c + 1 - k) / s == (w - k) / s);
			pending_results.push_back(res);
			results_predicted++;
		end
		if (c + 1 >= w) begin
			next_col = 0;
			next_row = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			next_col = c + 1;
		end
	endfunction

	function automatic logic [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(0, 7))
			0: return SAMPLE_MIN;
			1: return SAMPLE_MAX;
			2: return SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	// Result checker: every output transaction is matched against the oldest prediction.
	always @(posedge clk) begin
		pool_result_t got, want;
		if (m_tvalid && m_tready) begin
			got.pooled = m_tdata[SAMPLE_W-1:0];
			got.row    = m_tdata[ROW_LSB +: ROW_W];
			got.col    = m_tdata[COL_LSB +: COL_W];
			got.done   = m_tlast;
			if (pending_results.size() == 0) begin
				note_failure($sformatf("unexpected result: value %h row %0d col %0d last %0b",
					got.pooled, got.row, got.col, got.done));
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (got.pooled !== want.pooled || got.row !== want.row ||
				    got.col !== want.col || got.done !== want.done ||
				    m_tdata[OUT_DATA_W-1:PAD_LSB] !== '0) begin
					note_failure($sformatf({"result %0d: expected value %h row %0d col %0d ",
						"last %0b, got value %h row %0d col %0d last %0b pad %h"},
						results_checked, want.pooled, want.row, want.col, want.done,
						got.pooled, got.row, got.col, got.done,
						m_tdata[OUT_DATA_W-1:PAD_LSB]));
				end
			end
		end
	end

	// Receiver: short random stalls, or a long hold when a test asks for one.
	initial begin
		m_tready = 1'b1;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				m_tready = 1'b0;
				repeat (hold_request) @(negedge clk);
				hold_request = 0;
				m_tready = 1'b1;
			end else if (stalls_on && $urandom_range(0, 5) == 0) begin
				m_tready = 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				m_tready = 1'b1;
			end else begin
				m_tready = 1'b1;
			end
		end
	end

	task automatic send_sample(logic [SAMPLE_W-1:0] value);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tdata = value;
		do @(posedge clk); while (!s_tready);
		predict_sample(value);
		samples_sent++;
	endtask

	task automatic send_random(int count);
		repeat (count) send_sample(random_sample());
	endtask

	// Stops the input, waits for every predicted result, then lets the block settle.
	task automatic wait_idle();
		int waited;
		@(negedge clk);
		s_tvalid = 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_results.size() != 0) begin
			note_failure($sformatf("%0d expected results never arrived",
				pending_results.size()));
			pending_results.delete();
		end
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		apply_reg(idx, data);
	endtask

	task automatic configure(logic mode, int k, int s, int w, int h);
		wait_idle();
		write_reg(REG_POOL_MODE, CFG_DATA_W'(mode));
		write_reg(REG_KERNEL_SIZE, CFG_DATA_W'(k));
		write_reg(REG_STRIDE_STEP, CFG_DATA_W'(s));
		write_reg(REG_PLANE_WIDTH, CFG_DATA_W'(w));
		write_reg(REG_PLANE_HEIGHT, CFG_DATA_W'(h));
		settings_count++;
	endtask

	// Reset values: 2x2 max pooling, stride 2, 1024 wide; two full rows and two more samples.
	task automatic test_reset_defaults();
		send_random(2 * MAXW + 2);
	endtask

	task automatic test_value_extremes();
		logic [SAMPLE_W-1:0] corner_values [16] = '{
			SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN,
			16'hFFFF,   16'h0000,   SAMPLE_MIN, SAMPLE_MIN,
			SAMPLE_MAX, SAMPLE_MAX, 16'hFFFF,   16'hFFFF,
			SAMPLE_MAX, SAMPLE_MAX, 16'hFFFF,   16'h0000};
		configure(MODE_MAX, 2, 2, 4, 4);
		foreach (corner_values[i]) send_sample(corner_values[i]);
		// The plane has wrapped; a mode change alone keeps the position.
		wait_idle();
		write_reg(REG_POOL_MODE, CFG_DATA_W'(MODE_AVG));
		foreach (corner_values[i]) send_sample(corner_values[i]);
	endtask

	task automatic test_register_clamping();
		configure(MODE_MAX, 0, 0, 3, 2);
		send_random(9);
		// Kernel and stride fields all ones: kernel clamps to the maximum.
		configure(MODE_AVG, 11'h7FF, 11'h7FF, MAXK, MAXK);
		send_random(MAXK * MAXK);
		wait_idle();
		write_reg(REG_POOL_MODE, CFG_DATA_W'(MODE_MAX));
		send_random(MAXK * MAXK);
		configure(MODE_AVG, 1, 1, 0, 0);
		send_random(3);
		// Kernel wider than the plane: no results, counters still wrap.
		configure(MODE_MAX, 3, 1, 2, 2);
		send_random(10);
		configure(MODE_MAX, 1, 1, 2047, 2047);
		send_random(MAXW + 6);
		configure(MODE_AVG, 1, 1, 1, 2047);
		send_random(MAX_HEIGHT + 2);
	endtask

	task automatic test_pause_mid_plane();
		configure(MODE_MAX, 2, 1, 3, 3);
		send_random(5);
		wait_idle();
		for (int i = REG_UNUSED_FIRST; i <= REG_UNUSED_LAST; i++)
			write_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
		write_reg(REG_POOL_MODE, CFG_DATA_W'(MODE_AVG));
		send_random(4 + 9);
	endtask

	task automatic test_backpressure();
		configure(MODE_MAX, 1, 1, 8, 8);
		gaps_on = 1'b0;
		hold_request = 300;
		send_random(64);
		gaps_on = 1'b1;
	endtask

	task automatic test_random_planes();
		int k_raw, s_raw, w_raw, h_raw, k_eff, n, first_item, first_result;
		logic mode;
		logic [CFG_DATA_W-1:0] mode_word;
		first_item = samples_sent;
		first_result = results_predicted;
		while (samples_sent - first_item < RANDOM_ITEMS ||
		       results_predicted - first_result < MIN_RANDOM_RESULTS) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			stalls_on = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 9))
				0: k_raw = 0;
				1: k_raw = $urandom_range(MAXK + 1, 15);
				default: k_raw = $urandom_range(1, $urandom_range(1, MAXK));
			endcase
			k_eff = (k_raw == 0) ? 1 : ((k_raw > MAXK) ? MAXK : k_raw);
			case ($urandom_range(0, 9))
				0: s_raw = 0;
				1: s_raw = $urandom_range(MAXK + 1, 15);
				default: s_raw = $urandom_range(1, 4);
			endcase
			case ($urandom_range(0, 9))
				0: w_raw = 0;
				1: w_raw = $urandom_range(1, k_eff);
				default: w_raw = k_eff + $urandom_range(0, 12);
			endcase
			case ($urandom_range(0, 9))
				0: h_raw = 0;
				1: h_raw = $urandom_range(1, k_eff);
				default: h_raw = k_eff + $urandom_range(0, 5);
			endcase
			mode = $urandom_range(0, 1);
			configure(mode, k_raw, s_raw, w_raw, h_raw);
			n = ((w_raw == 0) ? 1 : w_raw) * ((h_raw == 0) ? 1 : h_raw) * $urandom_range(1, 2);
			// Now and then the plane is cut short by the next geometry write.
			if ($urandom_range(0, 4) == 0)
				n = $urandom_range(1, n);
			if ($urandom_range(0, 5) == 0) begin
				send_random(n / 2);
				wait_idle();
				mode_word = CFG_DATA_W'($urandom);
				mode_word[0] = ~mode;
				write_reg(REG_POOL_MODE, mode_word);
				send_random(n - n / 2);
			end else begin
				send_random(n);
			end
		end
	endtask

	task automatic test_full_rate_tail();
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		configure(MODE_AVG, 3, 2, 9, 7);
		send_random(2 * 9 * 7);
		configure(MODE_MAX, 2, 1, 5, 4);
		send_random(2 * 5 * 4);
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fail_count = 0;
		samples_sent = 0;
		results_predicted = 0;
		results_checked = 0;
		settings_count = 0;
		hold_request = 0;
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		next_row = 0;
		next_col = 0;
		cur_mode = MODE_MAX;
		cur_kernel = KERNEL_RST;
		cur_stride = STRIDE_RST;
		cur_width = WIDTH_RST;
		cur_height = HEIGHT_RST;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_value_extremes();
		test_register_clamping();
		test_pause_mid_plane();
		test_backpressure();
		test_random_planes();
		test_full_rate_tail();
		wait_idle();

		$display("Checked %0d pooled results from %0d samples over %0d register settings.",
			results_checked, samples_sent, settings_count);
		$display("Both modes, clamped registers, plane wrap, long output hold and random planes.");
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d failures", fail_count);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/p2d_pkg.sv
rtl/core/p2d_div.sv
rtl/core/pooling_2d_stream.sv
verif/tb_pooling_2d_stream.sv
